/* src/bals_pkg.sv */
// ----------------------------------------------------------------------------
// bals_pkg
// Shared types, widths and codes for the bounded adjacency list store.
// ----------------------------------------------------------------------------
package bals_pkg;

	localparam int MAX_VERTICES  = 256;
	localparam int MAX_NEIGHBORS = 16;
	localparam int WEIGHT_BITS   = 32;

	localparam int VTX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W      = VTX_W + 1;
	localparam int SLOT_W      = $clog2(MAX_NEIGHBORS);
	localparam int DEG_W       = $clog2(MAX_NEIGHBORS + 1);
	localparam int SLOT_ADDR_W = VTX_W + SLOT_W;
	localparam int SLOTS       = MAX_VERTICES * MAX_NEIGHBORS;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// register map (index = paddr[3:2])
	localparam logic [1:0] REG_VERTICES = 2'd0;
	localparam logic [1:0] REG_LIMIT    = 2'd1;
	localparam logic [1:0] REG_WEIGHTS  = 2'd2;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_MIRROR  = 3'd3;
	localparam logic [2:0] ST_MISSING = 3'd4;

	typedef struct packed {
		logic                   req_type;
		logic [VTX_W-1:0]       origin_vertex;
		logic [VTX_W-1:0]       dest_vertex;
		logic                   directed;
		logic [WEIGHT_BITS-1:0] edge_weight;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [DEG_W-1:0] origin_degree;
	} rsp_t;

	// live (saturated) configuration
	typedef struct packed {
		logic [VCNT_W-1:0] vcount;
		logic [DEG_W-1:0]  limit;
		logic              weights;
	} cfg_t;

endpackage

/* src/bounded_adjacency_list_store_unit.sv */
// ----------------------------------------------------------------------------
// bounded_adjacency_list_store_unit
// Graph store with bounded per-vertex neighbour lists: add / remove edge.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  req     | in        | req_valid/req_stall| req_type, vertices, dir, weight
//  rsp     | out       | rsp_valid/rsp_stall| status, origin_degree
//  apb     | in        | psel/penable/pready| 3 config registers at 0x0/0x4/0x8
//
//  Sequencing: a request runs through one shared sequencer; the neighbour
//  RAM gives one entry per cycle. An undirected request that succeeds on
//  the origin list repeats the work on the destination list; a remove
//  scans each list entry by entry up to its degree.
//  Reset: degree counts read as zero through per-vertex valid bits; the
//  neighbour and weight RAMs are not cleared and hold nothing until written.
//  Stalls: req_stall is high while a request is in flight; a finished
//  response waits in the output register so the next request may enter.
// ----------------------------------------------------------------------------
module bounded_adjacency_list_store_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bals_pkg::PADDR_W-1:0]    paddr,
	input  logic [bals_pkg::PDATA_W-1:0]    pwdata,
	output logic [bals_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  bals_pkg::req_t                  req,
	// response channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output bals_pkg::rsp_t                  rsp
);
	import bals_pkg::*;

	logic [VCNT_W-1:0] vertices_in_use_q;
	logic [DEG_W-1:0]  degree_limit_q;
	logic              weights_enabled_q;

	logic              cfg_wr;
	logic [1:0]        reg_idx;
	cfg_t              cfg;

	logic              busy, done, out_free;
	rsp_t              result;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// --- configuration registers -------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertices_in_use_q <= VCNT_W'(MAX_VERTICES);
			degree_limit_q    <= DEG_W'(MAX_NEIGHBORS);
			weights_enabled_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_VERTICES: vertices_in_use_q <= pwdata[VCNT_W-1:0];
				REG_LIMIT:    degree_limit_q    <= pwdata[DEG_W-1:0];
				REG_WEIGHTS:  weights_enabled_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VERTICES: prdata = PDATA_W'(vertices_in_use_q);
			REG_LIMIT:    prdata = PDATA_W'(degree_limit_q);
			REG_WEIGHTS:  prdata = PDATA_W'(weights_enabled_q);
			default:      prdata = '0;
		endcase
	end

	// out-of-range settings saturate at the built-in sizes
	assign cfg.vcount  = (vertices_in_use_q > VCNT_W'(MAX_VERTICES))
	                   ? VCNT_W'(MAX_VERTICES) : vertices_in_use_q;
	assign cfg.limit   = (degree_limit_q > DEG_W'(MAX_NEIGHBORS))
	                   ? DEG_W'(MAX_NEIGHBORS) : degree_limit_q;
	assign cfg.weights = weights_enabled_q;

	// --- sequencer -----------------------------------------------------------
	bals_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req       (req),
		.busy      (busy),
		.out_free  (out_free),
		.done      (done),
		.result    (result)
	);

	assign req_stall = busy;

	// --- response register ---------------------------------------------------
	// free when empty or being taken this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* src/bals_ram.sv */
// ----------------------------------------------------------------------------
// bals_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bals_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/bals_seq.sv */
// ----------------------------------------------------------------------------
// bals_seq
// Request sequencer: degree lookup, append, linear scan and swap-remove,
// run once per list over the shared neighbour/weight/degree RAMs.
// ----------------------------------------------------------------------------
module bals_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  bals_pkg::cfg_t cfg,
	input  logic          req_valid,
	input  bals_pkg::req_t req,
	output logic          busy,
	input  logic          out_free,
	output logic          done,
	output bals_pkg::rsp_t result
);
	import bals_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DRD  = 4'd1;
	localparam logic [3:0] S_DEG  = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_LAST = 4'd4;
	localparam logic [3:0] S_MOVE = 4'd5;
	localparam logic [3:0] S_FRD  = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]             state_q, state_d;
	req_t                   req_q;
	logic                   list_b_q;
	logic [VTX_W-1:0]       v_q;
	logic [VTX_W-1:0]       nb_q;
	logic [DEG_W-1:0]       deg_q;
	logic [DEG_W-1:0]       idx_q;
	logic                   cmp_vld_q;
	logic [SLOT_W-1:0]      cmp_idx_q;
	logic [SLOT_W-1:0]      hit_idx_q;
	logic [2:0]             status_q;
	logic [DEG_W-1:0]       rsp_deg_q;
	logic [MAX_VERTICES-1:0] vld_q;

	logic                   range_bad, is_add, room, hit, miss, issue;
	logic                   list_end, list_ok, go_b;
	logic [DEG_W-1:0]       deg_eff, fin_deg, deg_m1;

	logic                   nb_we, w_we;
	logic [SLOT_ADDR_W-1:0] nb_waddr, nb_raddr;
	logic [VTX_W-1:0]       nb_wdata, nb_rdata;
	logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
	logic [VTX_W-1:0]       deg_raddr;
	logic [DEG_W-1:0]       deg_wdata, deg_rdata;

	assign range_bad = ({1'b0, req.origin_vertex} >= cfg.vcount)
	                || ({1'b0, req.dest_vertex} >= cfg.vcount);
	assign is_add    = (req_q.req_type == REQ_ADD);
	// degree store has valid bits: an unwritten vertex reads as zero
	assign deg_eff   = vld_q[v_q] ? deg_rdata : '0;
	assign fin_deg   = vld_q[req_q.origin_vertex] ? deg_rdata : '0;
	assign deg_m1    = deg_q - DEG_W'(1);
	assign room      = (deg_eff < cfg.limit);
	// shared compare unit: one stored neighbour against the target per cycle
	assign hit       = cmp_vld_q && (nb_rdata == nb_q);
	assign miss      = !cmp_vld_q && (idx_q >= deg_q);
	assign issue     = (idx_q < deg_q) && !hit;

	assign list_end  = (state_q == S_DEG && is_add)
	                || (state_q == S_SCAN && !hit && miss)
	                || (state_q == S_MOVE);
	assign list_ok   = (state_q == S_DEG) ? room : (state_q == S_MOVE);
	assign go_b      = !list_b_q && list_ok && !req_q.directed;

	// memory ports
	assign deg_raddr = (state_q == S_FRD) ? req_q.origin_vertex : v_q;
	assign nb_raddr  = (state_q == S_LAST) ? {v_q, deg_m1[SLOT_W-1:0]}
	                                       : {v_q, idx_q[SLOT_W-1:0]};
	assign nb_we     = (state_q == S_DEG && is_add && room) || (state_q == S_MOVE);
	assign nb_waddr  = (state_q == S_MOVE) ? {v_q, hit_idx_q} : {v_q, deg_eff[SLOT_W-1:0]};
	assign nb_wdata  = (state_q == S_MOVE) ? nb_rdata : nb_q;
	assign w_we      = nb_we && cfg.weights;
	assign w_wdata   = (state_q == S_MOVE) ? w_rdata : req_q.edge_weight;
	assign deg_wdata = (state_q == S_MOVE) ? deg_m1 : deg_eff + DEG_W'(1);

	bals_ram #(.WIDTH(VTX_W), .DEPTH(SLOTS)) u_nb_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (nb_waddr),
		.wdata (nb_wdata),
		.raddr (nb_raddr),
		.rdata (nb_rdata)
	);

	bals_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(SLOTS)) u_w_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (nb_waddr),
		.wdata (w_wdata),
		.raddr (nb_raddr),
		.rdata (w_rdata)
	);

	bals_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (v_q),
		.wdata (deg_wdata),
		.raddr (deg_raddr),
		.rdata (deg_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = range_bad ? S_DONE : S_DRD;
				end
			end
			S_DRD:  state_d = S_DEG;
			S_DEG:  state_d = S_SCAN;
			S_SCAN: begin
				if (hit) begin
					state_d = S_LAST;
				end
			end
			S_LAST: state_d = S_MOVE;
			S_MOVE: state_d = S_FRD;
			S_FRD:  state_d = S_FIN;
			S_FIN:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (list_end) begin
			state_d = go_b ? S_DRD : S_FRD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			list_b_q  <= 1'b0;
			cmp_vld_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			state_q <= state_d;
			if (nb_we) begin
				vld_q[v_q] <= 1'b1;
			end
			if (state_q == S_IDLE) begin
				list_b_q <= 1'b0;
			end else if (list_end && go_b) begin
				list_b_q <= 1'b1;
			end
			if (state_q == S_SCAN && !hit) begin
				cmp_vld_q <= issue;
			end else begin
				cmp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q     <= req;
			v_q       <= req.origin_vertex;
			nb_q      <= req.dest_vertex;
			status_q  <= range_bad ? ST_RANGE : ST_OK;
			rsp_deg_q <= '0;
		end
		if (state_q == S_DEG) begin
			deg_q <= deg_eff;
			idx_q <= '0;
		end
		if (state_q == S_SCAN) begin
			if (issue) begin
				idx_q     <= idx_q + DEG_W'(1);
				cmp_idx_q <= idx_q[SLOT_W-1:0];
			end
			if (hit) begin
				hit_idx_q <= cmp_idx_q;
			end
		end
		if (list_end) begin
			if (go_b) begin
				v_q  <= req_q.dest_vertex;
				nb_q <= req_q.origin_vertex;
			end
			if (!list_b_q) begin
				status_q <= list_ok ? ST_OK : (is_add ? ST_FULL : ST_MISSING);
			end else if (is_add && !list_ok) begin
				status_q <= ST_MIRROR;
			end
		end
		if (state_q == S_FIN) begin
			rsp_deg_q <= fin_deg;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = (state_q == S_DONE) && out_free;
	assign result = '{status: status_q, origin_degree: rsp_deg_q};

	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |-> deg_q != '0)
		else $error("swap-remove on an empty list");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= deg_q)
		else $error("scan index beyond list degree");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_RANGE |-> result.origin_degree == '0)
		else $error("range error with non-zero degree");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && req_valid |=> busy)
		else $error("request taken but sequencer not busy");

endmodule

/* dv/bounded_adjacency_list_store_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_adjacency_list_store_unit_tb
// Drives add and remove edge requests into the graph store and checks each
// response, status and origin degree, against an in-bench model of the lists.
// ----------------------------------------------------------------------------
module bounded_adjacency_list_store_unit_tb;

	import bals_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int DRAIN_CYCLES   = 64;    // wind-down after the last response
	localparam int HOLD_CYCLES    = 300;   // long back-pressure stretch
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake or register access
	localparam int EDGE_MEMORY    = 64;    // recent adds kept for removes

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;

	// Requests still to be offered, and responses owed by the block
	req_t                 req_backlog [$];
	rsp_t                 awaited_rsp [$];
	logic [2*VTX_W:0]     added_edges [$];   // {directed, origin, dest}

	int                   req_total   = 0;   // requests queued so far
	int                   req_taken   = 0;   // requests accepted by the block
	int                   error_count = 0;
	int                   snd_idle_pct = 0;
	int                   rcv_stall_pct = 0;
	logic                 hold_wanted = 1'b0;

	// Shadow of the register file, raw as written
	logic [VCNT_W-1:0]    cfg_vertices = VCNT_W'(MAX_VERTICES);
	logic [DEG_W-1:0]     cfg_limit    = DEG_W'(MAX_NEIGHBORS);
	logic                 cfg_weights  = 1'b0;

	// Shadow of the graph: neighbour lists, weight words and degrees
	logic [VTX_W-1:0]       nbr_store  [MAX_VERTICES][MAX_NEIGHBORS];
	logic [WEIGHT_BITS-1:0] wt_store   [MAX_VERTICES][MAX_NEIGHBORS];
	logic [DEG_W-1:0]       list_len   [MAX_VERTICES];

	bounded_adjacency_list_store_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Graph model
	// ------------------------------------------------------------------------

	// Append nb to the list of v if the (saturated) limit allows it
	function automatic logic append_edge(input logic [VTX_W-1:0] v,
			input logic [VTX_W-1:0] nb, input logic [WEIGHT_BITS-1:0] w);
		int lim;
		int d;
		lim = (cfg_limit > MAX_NEIGHBORS) ? MAX_NEIGHBORS : cfg_limit;
		d = int'(list_len[v]);
		if (d >= lim)
			return 1'b0;
		nbr_store[v][SLOT_W'(d)] = nb;
		if (cfg_weights)
			wt_store[v][SLOT_W'(d)] = w;
		list_len[v] = DEG_W'(d + 1);
		return 1'b1;
	endfunction

	// Linear search of the whole stored list (not just up to the limit);
	// the last entry is moved into the hole
	function automatic logic drop_edge(input logic [VTX_W-1:0] v,
			input logic [VTX_W-1:0] nb);
		int d;
		int i;
		d = int'(list_len[v]);
		i = 0;
		while (i < d && nbr_store[v][SLOT_W'(i)] != nb)
			i++;
		if (i >= d)
			return 1'b0;
		d--;
		list_len[v] = DEG_W'(d);
		nbr_store[v][SLOT_W'(i)] = nbr_store[v][SLOT_W'(d)];
		if (cfg_weights)
			wt_store[v][SLOT_W'(i)] = wt_store[v][SLOT_W'(d)];
		return 1'b1;
	endfunction

	// Applies one request to the shadow graph and returns the response owed
	function automatic rsp_t graph_update(input req_t r);
		rsp_t o;
		int   nv;
		nv = (cfg_vertices > MAX_VERTICES) ? MAX_VERTICES : cfg_vertices;
		o = '0;
		if (r.origin_vertex >= nv || r.dest_vertex >= nv) begin
			// rejected outright, degree field reads zero
			o.status = ST_RANGE;
			return o;
		end
		if (r.req_type == REQ_ADD) begin
			if (!append_edge(r.origin_vertex, r.dest_vertex, r.edge_weight)) begin
				o.status = ST_FULL;
			end else if (!r.directed) begin
				// forward edge stays even when the mirror list is full
				if (append_edge(r.dest_vertex, r.origin_vertex, r.edge_weight))
					o.status = ST_OK;
				else
					o.status = ST_MIRROR;
			end else begin
				o.status = ST_OK;
			end
		end else begin
			if (!drop_edge(r.origin_vertex, r.dest_vertex)) begin
				o.status = ST_MISSING;
			end else begin
				// mirror removal outcome is not reported
				if (!r.directed)
					void'(drop_edge(r.dest_vertex, r.origin_vertex));
				o.status = ST_OK;
			end
		end
		o.origin_degree = list_len[r.origin_vertex];
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: one NBA per signal per edge, payload frozen while stalled
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				awaited_rsp.push_back(graph_update(req));
				req_taken++;
			end
			if (!(req_valid && req_stall)) begin
				if (req_backlog.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response monitor and receiver back-pressure
	// ------------------------------------------------------------------------
	int   hold_left = 0;
	logic hold_done = 1'b0;
	rsp_t rsp_owed;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: response with none outstanding: expected none, got status %0d degree %0d",
						$time, rsp.status, rsp.origin_degree);
					error_count++;
				end else begin
					rsp_owed = awaited_rsp.pop_front();
					if (rsp.status !== rsp_owed.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, rsp_owed.status, rsp.status);
						error_count++;
					end
					if (rsp.origin_degree !== rsp_owed.origin_degree) begin
						$display("%0t: origin_degree mismatch: expected %0d, got %0d",
							$time, rsp_owed.origin_degree, rsp.origin_degree);
						error_count++;
					end
				end
			end
			// one long hold on request, so the block fills and stalls its input
			if (hold_wanted && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: any handshake or register access counts as progress
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Only called with the block idle
	task automatic set_config(input int v, input int l, input logic w);
		write_reg(REG_VERTICES, v);
		cfg_vertices = VCNT_W'(v);
		write_reg(REG_LIMIT, l);
		cfg_limit = DEG_W'(l);
		write_reg(REG_WEIGHTS, PDATA_W'(w));
		cfg_weights = w;
	endtask

	task automatic post_request(input logic op, input int o, input int d,
			input logic dir, input logic [WEIGHT_BITS-1:0] w);
		req_t r;
		r.req_type      = op;
		r.origin_vertex = VTX_W'(o);
		r.dest_vertex   = VTX_W'(d);
		r.directed      = dir;
		r.edge_weight   = w;
		req_backlog.push_back(r);
		req_total++;
	endtask

	// Everything accepted and answered, then let the sequencer wind down
	task automatic settle();
		while (req_taken != req_total || awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Mostly adds/removes inside a small window of vertices so lists fill and
	// removes hit; removes often take back a recently added edge. The rest is
	// scattered over the whole field range (out of range when few vertices).
	task automatic queue_random(input int count);
		int                     nv;
		int                     span;
		int                     base;
		int                     k;
		int                     idx;
		int                     roll;
		logic [VTX_W-1:0]       o;
		logic [VTX_W-1:0]       d;
		logic                   dir;
		logic                   op;
		logic [WEIGHT_BITS-1:0] w;
		nv   = (cfg_vertices > MAX_VERTICES) ? MAX_VERTICES : cfg_vertices;
		span = (nv < 8) ? nv : 8;
		base = (nv > 8) ? $urandom_range(0, nv - 8) : 0;
		for (k = 0; k < count; k++) begin
			op   = ($urandom_range(0, 99) < 45) ? REQ_REMOVE : REQ_ADD;
			dir  = 1'($urandom_range(0, 1));
			roll = $urandom_range(0, 9);
			w    = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
			if (op == REQ_REMOVE && added_edges.size() > 0 && $urandom_range(0, 99) < 60) begin
				idx = $urandom_range(0, added_edges.size() - 1);
				{dir, o, d} = added_edges[idx];
				added_edges.delete(idx);
				if ($urandom_range(0, 9) == 0)
					dir = ~dir;
			end else if (span == 0 || $urandom_range(0, 99) < 20) begin
				o = VTX_W'($urandom_range(0, MAX_VERTICES - 1));
				d = VTX_W'($urandom_range(0, MAX_VERTICES - 1));
			end else begin
				o = VTX_W'(base + $urandom_range(0, span - 1));
				d = VTX_W'(base + $urandom_range(0, span - 1));
			end
			if (op == REQ_ADD) begin
				added_edges.push_back({dir, o, d});
				if (added_edges.size() > EDGE_MEMORY)
					void'(added_edges.pop_front());
			end
			post_request(op, int'(o), int'(d), dir, w);
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	// Random phases: register settings, idling profile and request count.
	// Weights stay on until the last phases and are never switched back on,
	// so no weight slot is ever moved before it has been written.
	int   ph_vert [7] = '{256, 6, 1, 40, 300, 256, 256};
	int   ph_lim  [7] = '{16, 3, 31, 16, 1, 0, 12};
	logic ph_wt   [7] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
	int   ph_mode [7] = '{0, 0, 1, 1, 2, 2, 2};
	int   ph_count[7] = '{180, 160, 100, 200, 150, 60, 200};

	initial begin
		logic [2:0] p;
		foreach (list_len[v])
			list_len[v] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles 32 %, receiver stalls 76 %
		snd_idle_pct  = 32;
		rcv_stall_pct = 76;

		// full size, weights on from the very first add
		set_config(256, 16, 1'b1);
		post_request(REQ_ADD,    0, 255, 1'b1, 32'hFFFF_FFFF);
		post_request(REQ_ADD,  255,   0, 1'b0, 32'h0000_0000);
		post_request(REQ_ADD,    5,   5, 1'b0, 32'hA5A5_A5A5);  // self loop: two entries
		post_request(REQ_REMOVE, 5,   5, 1'b0, 32'h0);          // mirror takes the second
		post_request(REQ_REMOVE, 7,   8, 1'b1, 32'h0);          // not found
		post_request(REQ_REMOVE, 0, 255, 1'b0, 32'h0);
		settle();

		// zero vertices: everything rejected; zero limit as well
		set_config(0, 0, 1'b1);
		post_request(REQ_ADD,    0, 0, 1'b1, 32'h1234_5678);
		post_request(REQ_REMOVE, 0, 0, 1'b0, 32'h0);
		settle();

		// three vertices, two neighbours: origin full, mirror full, range
		set_config(3, 2, 1'b1);
		post_request(REQ_ADD, 2, 1, 1'b1, 32'h0000_0001);
		post_request(REQ_ADD, 2, 0, 1'b1, 32'h8000_0000);
		post_request(REQ_ADD, 2, 0, 1'b1, 32'h0);
		post_request(REQ_ADD, 1, 2, 1'b0, 32'h5A5A_5A5A);       // mirror list full
		post_request(REQ_ADD, 3, 0, 1'b1, 32'h0);
		post_request(REQ_ADD, 0, 3, 1'b0, 32'h0);
		settle();

		// limit dropped below the degree of vertex 2: add fails, remove scans all
		set_config(3, 1, 1'b1);
		post_request(REQ_ADD,    2, 2, 1'b1, 32'h0);
		post_request(REQ_REMOVE, 2, 0, 1'b1, 32'h0);
		settle();

		// register values above the parameters saturate
		set_config(511, 31, 1'b1);
		post_request(REQ_ADD,    255, 254, 1'b1, 32'hFFFF_FFFF);
		post_request(REQ_REMOVE, 255, 254, 1'b0, 32'h0);        // mirror missing, ignored
		settle();

		for (p = 3'd0; p < 3'd7; p++) begin
			case (ph_mode[p])
				0: begin
					snd_idle_pct  = 32;
					rcv_stall_pct = 76;
				end
				1: begin
					snd_idle_pct  = 76;
					rcv_stall_pct = 32;
				end
				default: begin
					snd_idle_pct  = 0;
					rcv_stall_pct = 0;
				end
			endcase
			set_config(ph_vert[p], ph_lim[p], ph_wt[p]);
			if (p == 3'd0)
				hold_wanted = 1'b1;
			queue_random(ph_count[p]);
			settle();
		end

		if (error_count == 0 && awaited_rsp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* bounded_adjacency_list_store_unit.f */
src/bals_pkg.sv
src/bals_ram.sv
src/bals_seq.sv
src/bounded_adjacency_list_store_unit.sv
dv/bounded_adjacency_list_store_unit_tb.sv
